[rtl/phre_pkg.sv]
// Shared types and constants for the grey-map header parser and run-length encoder.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package phre_pkg;

   // Port widths fixed by the item formats.
   localparam int PIXEL_BITS = 8;
   localparam int RUN_BITS   = 16;
   localparam int DIM_PORT_BITS = 16;
   localparam int KIND_BITS  = 2;

   // Longest run that one run item can carry.
   localparam logic [RUN_BITS-1:0] RUN_MAX = 16'hFFFF;

   // Characters that steer the header parser.
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   // Result queue geometry.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int FIFO_CW    = 3;

   typedef enum logic [2:0] {
      PH_MAGIC  = 3'd0,
      PH_WIDTH  = 3'd1,
      PH_HEIGHT = 3'd2,
      PH_MAXVAL = 3'd3,
      PH_PIXELS = 3'd4,
      PH_DONE   = 3'd5,
      PH_DRAIN  = 3'd6
   } phase_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_HEADER   = 2'd0,
      KIND_RUN      = 2'd1,
      KIND_MISMATCH = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [RUN_BITS-1:0]       run_length;
      logic [PIXEL_BITS-1:0]     pixel_value;
      logic [DIM_PORT_BITS-1:0]  image_width;
      logic [DIM_PORT_BITS-1:0]  image_height;
      logic [DIM_PORT_BITS-1:0]  max_value;
      logic                      bad_digit;
      logic                      last;
   } result_type;

endpackage

[rtl/phre_if.sv]
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on phre_pkg for field widths.
interface phre_req_if;
   logic                           valid;
   logic                           ready;
   logic [phre_pkg::PIXEL_BITS-1:0] data_byte;
   logic                           end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface phre_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [phre_pkg::KIND_BITS-1:0]     result_kind;
   logic [phre_pkg::RUN_BITS-1:0]      run_length;
   logic [phre_pkg::PIXEL_BITS-1:0]    pixel_value;
   logic [phre_pkg::DIM_PORT_BITS-1:0] image_width;
   logic [phre_pkg::DIM_PORT_BITS-1:0] image_height;
   logic [phre_pkg::DIM_PORT_BITS-1:0] max_value;
   logic                              bad_digit;
   logic                              last;

   modport source (output valid, output result_kind, output run_length, output pixel_value,
                   output image_width, output image_height, output max_value,
                   output bad_digit, output last, input ready);
   modport sink   (input valid, input result_kind, input run_length, input pixel_value,
                   input image_width, input image_height, input max_value,
                   input bad_digit, input last, output ready);
endinterface

[rtl/pgm_header_parse_rle_encode_top.sv]
// Top level of the binary grey-map header parser and run-length encoder.
// Depends on phre_pkg and on the channel interfaces in phre_if.sv.

// The block takes a binary grey-map file one byte per item on req_chan and
// returns result items on rsp_chan. The magic line is skipped; width (ended
// by a space), height and maximum value (each ended by a newline) are read
// as decimal numbers that saturate at 2^DIM_BITS-1, and any non-digit inside
// them is dropped and raises bad_digit. The newline after the maximum value
// yields a header item. The following width*height bytes are pixels, coded
// as runs that continue across row ends; a run is closed by a change of
// value, by reaching 65535, or by the last pixel, which carries last = 1.
// A byte after the last pixel, or end_of_file before it, yields one size
// mismatch item with last = 1, and end_of_file always returns the parser to
// its reset state for the next file. Each byte is handled in the cycle it is
// accepted and its results enter a four-entry result queue, whose registered
// head drives rsp_chan. While the queue has room the block takes one byte
// every cycle; a byte can produce at most two results and the queue drains
// one per cycle, so req_chan.ready drops whenever fewer than two queue
// entries are free. A byte with two results is always followed by bytes
// with at most one, so with rsp_chan always ready the queue holds at most
// two items and the input never stalls; only a stalled rsp_chan closes it.
// The single 2*DIM_BITS-bit width*height product is formed at the
// maximum-value newline and registered.
module pgm_header_parse_rle_encode_top #(
   parameter int DIM_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   phre_req_if.sink         req_chan,
   phre_rsp_if.source       rsp_chan
);

   localparam int PL_BITS  = 2 * DIM_BITS;
   localparam int MAC_BITS = DIM_BITS + 4;
   localparam logic [DIM_BITS-1:0] DIM_MAX = {DIM_BITS{1'b1}};

   // Parser and run state.
   phre_pkg::phase_type                phase_ff, phase_in, phase_step;
   logic [DIM_BITS-1:0]                acc_ff, acc_in;
   logic [DIM_BITS-1:0]                width_ff, width_in;
   logic [DIM_BITS-1:0]                height_ff, height_in;
   logic [PL_BITS-1:0]                 pixels_left_ff, pixels_left_in;
   logic [phre_pkg::PIXEL_BITS-1:0]    run_value_ff, run_value_in;
   logic [phre_pkg::RUN_BITS-1:0]      run_count_ff, run_count_in;
   logic                               digit_err_ff, digit_err_in;

   // Result queue.
   phre_pkg::result_type               fifo_ff [phre_pkg::FIFO_DEPTH];
   logic [phre_pkg::FIFO_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [phre_pkg::FIFO_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [phre_pkg::FIFO_CW-1:0]       count_ff, count_in;

   logic                               req_fire;
   logic                               rsp_fire;
   logic [phre_pkg::PIXEL_BITS-1:0]    byte_q;
   logic                               eof_q;
   logic                               is_digit;
   logic [7:0]                         digit_diff;
   logic [MAC_BITS-1:0]                acc_mac;
   logic [DIM_BITS-1:0]                acc_sat;
   logic                               dims_zero;
   logic [PL_BITS-1:0]                 area;
   logic                               run_start;
   logic                               run_extend;
   logic                               run_break;
   logic [phre_pkg::PIXEL_BITS-1:0]    rv_step;
   logic [phre_pkg::RUN_BITS-1:0]      rc_step;
   logic                               pix_last;

   logic                               r0_valid, r1_valid;
   phre_pkg::result_type               r0, r1, push_first;
   logic [1:0]                         push_n;
   phre_pkg::result_type               fifo_q;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign byte_q   = req_chan.data_byte;
   assign eof_q    = req_chan.end_of_file;

   // Decimal accumulate: acc * 10 + digit, built from two shifts, then saturated.
   assign is_digit   = byte_q inside {[phre_pkg::CHAR_ZERO:phre_pkg::CHAR_NINE]};
   assign digit_diff = byte_q - phre_pkg::CHAR_ZERO;
   assign acc_mac    = MAC_BITS'({acc_ff, 3'b000}) + MAC_BITS'({acc_ff, 1'b0})
                     + MAC_BITS'(digit_diff[3:0]);
   assign acc_sat    = (acc_mac > MAC_BITS'(DIM_MAX)) ? DIM_MAX : acc_mac[DIM_BITS-1:0];

   // An empty image is known from the operands, so the product is only registered.
   assign dims_zero = (width_ff == '0) || (height_ff == '0);
   assign area      = PL_BITS'(width_ff) * PL_BITS'(height_ff);

   // One pixel step of the run coder.
   assign run_start  = (run_count_ff == '0);
   assign run_extend = !run_start && (byte_q == run_value_ff)
                       && (run_count_ff != phre_pkg::RUN_MAX);
   assign run_break  = !run_start && !run_extend;
   assign rv_step    = run_extend ? run_value_ff : byte_q;
   assign rc_step    = run_extend ? (run_count_ff + 1'b1) : phre_pkg::RUN_BITS'(1);
   assign pix_last   = (pixels_left_ff == PL_BITS'(1));

   // Next state of the parser.
   always_comb begin
      phase_step     = phase_ff;
      acc_in         = acc_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      pixels_left_in = pixels_left_ff;
      run_value_in   = run_value_ff;
      run_count_in   = run_count_ff;
      digit_err_in   = digit_err_ff;

      case (phase_ff)
         phre_pkg::PH_MAGIC: begin
            if (byte_q == phre_pkg::CHAR_NEWLINE) begin
               phase_step = phre_pkg::PH_WIDTH;
            end
         end
         phre_pkg::PH_WIDTH: begin
            if (byte_q == phre_pkg::CHAR_SPACE) begin
               width_in   = acc_ff;
               acc_in     = '0;
               phase_step = phre_pkg::PH_HEIGHT;
            end else if (is_digit) begin
               acc_in = acc_sat;
            end else begin
               digit_err_in = 1'b1;
            end
         end
         phre_pkg::PH_HEIGHT: begin
            if (byte_q == phre_pkg::CHAR_NEWLINE) begin
               height_in  = acc_ff;
               acc_in     = '0;
               phase_step = phre_pkg::PH_MAXVAL;
            end else if (is_digit) begin
               acc_in = acc_sat;
            end else begin
               digit_err_in = 1'b1;
            end
         end
         phre_pkg::PH_MAXVAL: begin
            if (byte_q == phre_pkg::CHAR_NEWLINE) begin
               acc_in         = '0;
               pixels_left_in = area;
               run_count_in   = '0;
               phase_step     = dims_zero ? phre_pkg::PH_DONE : phre_pkg::PH_PIXELS;
            end else if (is_digit) begin
               acc_in = acc_sat;
            end else begin
               digit_err_in = 1'b1;
            end
         end
         phre_pkg::PH_PIXELS: begin
            run_value_in   = rv_step;
            run_count_in   = rc_step;
            pixels_left_in = pixels_left_ff - 1'b1;
            if (pix_last) begin
               run_count_in = '0;
               phase_step   = phre_pkg::PH_DONE;
            end
         end
         phre_pkg::PH_DONE: begin
            phase_step = phre_pkg::PH_DRAIN;
         end
         default: begin
            // Trailing bytes after the mismatch item are dropped.
         end
      endcase

      phase_in = phase_step;
      if (eof_q) begin
         phase_in       = phre_pkg::PH_MAGIC;
         acc_in         = '0;
         width_in       = '0;
         height_in      = '0;
         pixels_left_in = '0;
         run_value_in   = '0;
         run_count_in   = '0;
         digit_err_in   = 1'b0;
      end
   end

   // Results of the current byte: at most two, in order r0 then r1.
   always_comb begin
      r0_valid = 1'b0;
      r1_valid = 1'b0;
      r0       = '0;
      r1       = '0;

      case (phase_ff)
         phre_pkg::PH_MAXVAL: begin
            if (byte_q == phre_pkg::CHAR_NEWLINE) begin
               r0_valid        = 1'b1;
               r0.kind         = phre_pkg::KIND_HEADER;
               r0.image_width  = phre_pkg::DIM_PORT_BITS'(width_ff);
               r0.image_height = phre_pkg::DIM_PORT_BITS'(height_ff);
               r0.max_value    = phre_pkg::DIM_PORT_BITS'(acc_ff);
               r0.bad_digit    = digit_err_ff;
               r0.last         = dims_zero;
            end
         end
         phre_pkg::PH_PIXELS: begin
            if (run_break) begin
               r0_valid       = 1'b1;
               r0.kind        = phre_pkg::KIND_RUN;
               r0.run_length  = run_count_ff;
               r0.pixel_value = run_value_ff;
            end
            if (pix_last) begin
               r1_valid       = 1'b1;
               r1.kind        = phre_pkg::KIND_RUN;
               r1.run_length  = rc_step;
               r1.pixel_value = rv_step;
               r1.last        = 1'b1;
            end
         end
         phre_pkg::PH_DONE: begin
            r0_valid = 1'b1;
            r0.kind  = phre_pkg::KIND_MISMATCH;
            r0.last  = 1'b1;
         end
         default: begin
         end
      endcase

      // A file that ends before its last pixel closes with a mismatch item.
      if (eof_q && (phase_step < phre_pkg::PH_DONE)) begin
         r1_valid = 1'b1;
         r1       = '0;
         r1.kind  = phre_pkg::KIND_MISMATCH;
         r1.last  = 1'b1;
      end
   end

   // Queue bookkeeping. Results are packed so the first valid one goes first.
   assign push_n     = req_fire ? (2'(r0_valid) + 2'(r1_valid)) : 2'd0;
   assign push_first = r0_valid ? r0 : r1;
   assign wr_ptr_in  = wr_ptr_ff + phre_pkg::FIFO_AW'(push_n);
   assign rd_ptr_in  = rd_ptr_ff + phre_pkg::FIFO_AW'(rsp_fire);
   assign count_in   = count_ff + phre_pkg::FIFO_CW'(push_n) - phre_pkg::FIFO_CW'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= phre_pkg::PH_MAGIC;
         acc_ff         <= '0;
         width_ff       <= '0;
         height_ff      <= '0;
         pixels_left_ff <= '0;
         run_value_ff   <= '0;
         run_count_ff   <= '0;
         digit_err_ff   <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         if (req_fire) begin
            phase_ff       <= phase_in;
            acc_ff         <= acc_in;
            width_ff       <= width_in;
            height_ff      <= height_in;
            pixels_left_ff <= pixels_left_in;
            run_value_ff   <= run_value_in;
            run_count_ff   <= run_count_in;
            digit_err_ff   <= digit_err_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= push_first;
      end
      if (push_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + 1'b1] <= r1;
      end
   end

   // Room for the worst case of two results keeps the input side open.
   assign req_chan.ready = (count_ff <= phre_pkg::FIFO_CW'(phre_pkg::FIFO_DEPTH - 2));

   assign fifo_q                = fifo_ff[rd_ptr_ff];
   assign rsp_chan.valid        = (count_ff != '0);
   assign rsp_chan.result_kind  = fifo_q.kind;
   assign rsp_chan.run_length   = fifo_q.run_length;
   assign rsp_chan.pixel_value  = fifo_q.pixel_value;
   assign rsp_chan.image_width  = fifo_q.image_width;
   assign rsp_chan.image_height = fifo_q.image_height;
   assign rsp_chan.max_value    = fifo_q.max_value;
   assign rsp_chan.bad_digit    = fifo_q.bad_digit;
   assign rsp_chan.last         = fifo_q.last;

   // The queue never holds more than its depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= phre_pkg::FIFO_CW'(phre_pkg::FIFO_DEPTH))
      else $error("result queue overfilled");

   // While pixels are expected, at least one is still outstanding.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == phre_pkg::PH_PIXELS) |-> (pixels_left_ff != '0))
      else $error("pixel phase with no pixels left");

   // No run is open outside the pixel phase.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != phre_pkg::PH_PIXELS) |-> (run_count_ff == '0))
      else $error("open run outside pixel phase");

   // An end-of-file byte always sends the parser back to the magic line.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && eof_q) |=> (phase_ff == phre_pkg::PH_MAGIC))
      else $error("end of file did not restart the parser");

endmodule
